// ===== hdl/zpmf_pkg.sv =====
`default_nettype none
package zpmf_pkg;

    localparam int CFG_DW = 16;
    localparam int CFG_IW = 2;
    localparam int CNT_W  = 6;

    // largest supported kernel; the window radius is held in two bits
    localparam int MAX_KERNEL = 7;

    localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_KERNEL_SIZE   = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_THREE_CHANNEL = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } t_in_item;

    typedef struct packed {
        logic [7:0] median0;
        logic [7:0] median1;
        logic [7:0] median2;
        logic       frame_end;
    } t_out_item;

    // frame geometry as seen by front and back
    typedef struct packed {
        logic [15:0] hm1;
        logic [1:0]  rad;
        logic        three;
    } t_geom;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_WAIT,
        B_DECIDE,
        B_PUT
    } t_bstate;

    // rank of the median inside a (2r+1)^2 window
    function automatic logic [CNT_W-1:0] median_rank(input logic [1:0] rad);
        logic [CNT_W-1:0] k;
        case (rad)
            2'd0:    k = 6'd0;
            2'd1:    k = 6'd4;
            2'd2:    k = 6'd12;
            2'd3:    k = 6'd24;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/zpmf_ram.sv =====
`default_nettype none
module zpmf_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/zpmf_queue.sv =====
`default_nettype none
module zpmf_queue #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_head,
    output logic              o_empty,
    output logic              o_full
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/zpmf_front.sv =====
`default_nettype none
module zpmf_front
    import zpmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int ROWS      = 8,
    localparam int ColW  = $clog2(MAX_WIDTH),
    localparam int SlotW = $clog2(ROWS),
    localparam int AW    = $clog2(ROWS * MAX_WIDTH),
    localparam int JW    = 1 + SlotW + ColW + 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clr,
    input  wire logic [ColW-1:0] i_wm1,
    input  wire t_geom           i_geom,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire t_in_item        i_item,
    output logic                 o_wr_en,
    output logic      [AW-1:0]   o_wr_addr,
    output logic      [23:0]     o_wr_data,
    output logic                 o_push,
    output logic      [JW-1:0]   o_job,
    input  wire logic            i_q_full,
    input  wire logic            i_q_empty,
    input  wire logic [JW-1:0]   i_head,
    input  wire logic            i_pop
);
    logic [15:0]      r_in_row, n_in_row, r_out_row, n_out_row;
    logic [ColW-1:0]  r_in_col, n_in_col, r_out_col, n_out_col;
    logic [SlotW-1:0] r_in_slot, n_in_slot, r_out_slot, n_out_slot;
    logic             r_fc, n_fc, r_last_pend, n_last_pend;

    logic             acc, pix, clob_ok, ready_res, last;
    logic [17:0]      lim;
    logic [16:0]      ry;
    logic [ColW:0]    rx;

    assign lim     = {2'b0, i_head[15:0]} + 18'(ROWS - 1) - {16'b0, i_geom.rad};
    assign clob_ok = i_q_empty || ({2'b0, r_in_row} <= lim);
    assign o_ready = !i_q_full && !r_last_pend && clob_ok;
    assign acc     = i_valid && o_ready;
    assign pix     = acc && (i_item.kind == KIND_PIXEL) && !r_fc;
    assign last    = (r_out_row == i_geom.hm1) && (r_out_col == i_wm1);

    always_comb begin
        ry = {1'b0, r_out_row} + {15'b0, i_geom.rad};
        if (ry > {1'b0, i_geom.hm1}) begin
            ry = {1'b0, i_geom.hm1};
        end
        rx = {1'b0, r_out_col} + (ColW+1)'(i_geom.rad);
        if (rx > {1'b0, i_wm1}) begin
            rx = {1'b0, i_wm1};
        end
    end

    always_comb begin
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_in_slot   = r_in_slot;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_slot  = r_out_slot;
        n_fc        = r_fc;
        n_last_pend = r_last_pend;
        if (pix) begin
            if (r_in_row == i_geom.hm1 && r_in_col == i_wm1) begin
                n_fc = 1'b1;
            end else if (r_in_col == i_wm1) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + 16'd1;
                n_in_slot = (r_in_slot == SlotW'(ROWS - 1)) ? '0 : r_in_slot + SlotW'(1);
            end else begin
                n_in_col = r_in_col + ColW'(1);
            end
        end
        ready_res = n_fc || ({1'b0, n_in_row} > ry)
                  || ({1'b0, n_in_row} == ry && {1'b0, n_in_col} > rx);
        o_push = acc && ready_res;
        if (i_pop && i_head[JW-1]) begin
            n_last_pend = 1'b0;
        end
        if (o_push) begin
            if (last) begin
                n_in_row    = '0;
                n_in_col    = '0;
                n_in_slot   = '0;
                n_out_row   = '0;
                n_out_col   = '0;
                n_out_slot  = '0;
                n_fc        = 1'b0;
                n_last_pend = 1'b1;
            end else if (r_out_col == i_wm1) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + 16'd1;
                n_out_slot = (r_out_slot == SlotW'(ROWS - 1)) ? '0 : r_out_slot + SlotW'(1);
            end else begin
                n_out_col = r_out_col + ColW'(1);
            end
        end
    end

    assign o_job     = {last, r_out_slot, r_out_col, r_out_row};
    assign o_wr_en   = pix;
    assign o_wr_addr = AW'(r_in_slot * MAX_WIDTH) + AW'(r_in_col);
    assign o_wr_data = i_geom.three ? {i_item.chan2, i_item.chan1, i_item.chan0}
                                    : {16'b0, i_item.chan0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_slot   <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_slot  <= '0;
            r_fc        <= 1'b0;
            r_last_pend <= 1'b0;
        end else begin
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_in_slot   <= n_in_slot;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_slot  <= n_out_slot;
            r_fc        <= n_fc;
            r_last_pend <= n_last_pend;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/zpmf_back.sv =====
`default_nettype none
module zpmf_back
    import zpmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int ROWS      = 8,
    localparam int ColW  = $clog2(MAX_WIDTH),
    localparam int SlotW = $clog2(ROWS),
    localparam int AW    = $clog2(ROWS * MAX_WIDTH),
    localparam int JW    = 1 + SlotW + ColW + 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [ColW-1:0] i_wm1,
    input  wire t_geom           i_geom,
    input  wire logic            i_q_empty,
    input  wire logic [JW-1:0]   i_head,
    output logic                 o_pop,
    output logic                 o_rd_en,
    output logic      [AW-1:0]   o_rd_addr,
    input  wire logic [23:0]     i_rd_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output t_out_item            o_item
);
    t_bstate            r_state, n_state;
    logic [2:0]         r_b, r_wy, r_wx;
    logic               r_pv, r_pz, r_ov;
    logic [CNT_W-1:0]   r_cnt [3];
    logic [CNT_W-1:0]   r_k [3];
    logic [7:0]         r_pre [3];

    logic [15:0]        j_row;
    logic [ColW-1:0]    j_col;
    logic [SlotW-1:0]   j_slot;
    logic               j_last;
    logic [2:0]         span;
    logic               last_pos, inb, load;
    logic signed [17:0] y;
    logic signed [ColW+1:0] x;
    logic signed [SlotW+1:0] sd;
    logic [SlotW-1:0]   slot;
    logic [7:0]         hmask;
    logic [2:0]         hit;

    assign {j_last, j_slot, j_col, j_row} = i_head;
    assign span     = {i_geom.rad, 1'b0};
    assign last_pos = (r_wy == span) && (r_wx == span);

    always_comb begin
        y  = $signed({2'b0, j_row}) + $signed({15'b0, r_wy}) - $signed({16'b0, i_geom.rad});
        x  = $signed({2'b0, j_col}) + $signed((ColW+2)'(r_wx))
           - $signed((ColW+2)'(i_geom.rad));
        inb = (y >= 0) && (y <= $signed({2'b0, i_geom.hm1}))
           && (x >= 0) && (x <= $signed({2'b0, i_wm1}));
        sd = $signed({2'b0, j_slot}) + $signed((SlotW+2)'(r_wy))
           - $signed((SlotW+2)'(i_geom.rad));
        if (sd < 0) begin
            sd = sd + $signed((SlotW+2)'(ROWS));
        end else if (sd >= $signed((SlotW+2)'(ROWS))) begin
            sd = sd - $signed((SlotW+2)'(ROWS));
        end
        slot = sd[SlotW-1:0];
    end

    assign o_rd_addr = AW'(slot * MAX_WIDTH) + AW'(x[ColW-1:0]);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            hmask[i] = (i > int'(r_b));
        end
        for (int c = 0; c < 3; c++) begin
            logic [7:0] s;
            s = r_pz ? 8'd0 : i_rd_data[8*c +: 8];
            hit[c] = (((s ^ r_pre[c]) & hmask) == 8'd0) && !s[r_b];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (!i_q_empty) n_state = B_SCAN;
            B_SCAN:   if (last_pos) n_state = B_WAIT;
            B_WAIT:   n_state = B_DECIDE;
            B_DECIDE: n_state = (r_b == 3'd0) ? B_PUT : B_SCAN;
            B_PUT:    if (!r_ov || i_ready) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_rd_en = 1'b0;
        load    = 1'b0;
        case (r_state)
            B_SCAN:  o_rd_en = inb;
            B_PUT:   load    = !r_ov || i_ready;
            default: begin
                o_rd_en = 1'b0;
                load    = 1'b0;
            end
        endcase
    end

    assign o_pop   = load;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == B_SCAN);
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pz <= !inb;
        case (r_state)
            B_IDLE: begin
                r_b  <= 3'd7;
                r_wy <= '0;
                r_wx <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_pre[c] <= '0;
                    r_k[c]   <= median_rank(i_geom.rad);
                    r_cnt[c] <= '0;
                end
            end
            B_DECIDE: begin
                r_b  <= r_b - 3'd1;
                r_wy <= '0;
                r_wx <= '0;
                for (int c = 0; c < 3; c++) begin
                    if (r_k[c] >= r_cnt[c]) begin
                        r_pre[c][r_b] <= 1'b1;
                        r_k[c]        <= r_k[c] - r_cnt[c];
                    end
                    r_cnt[c] <= '0;
                end
            end
            default: begin
                if (r_state == B_SCAN) begin
                    if (r_wx == span) begin
                        r_wx <= '0;
                        r_wy <= r_wy + 3'd1;
                    end else begin
                        r_wx <= r_wx + 3'd1;
                    end
                end
                if (r_pv) begin
                    for (int c = 0; c < 3; c++) begin
                        r_cnt[c] <= r_cnt[c] + CNT_W'(hit[c]);
                    end
                end
            end
        endcase
        if (load) begin
            o_item.median0   <= r_pre[0];
            o_item.median1   <= i_geom.three ? r_pre[1] : 8'd0;
            o_item.median2   <= i_geom.three ? r_pre[2] : 8'd0;
            o_item.frame_end <= j_last;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/zero_padded_median_filter.sv =====
`default_nettype none
// Streaming median filter over a raster frame, zero padded, one or three
// 8-bit channels. Pixels and drain ticks enter through a front end that
// writes the line store and decides whether an item releases a result; jobs
// wait in a two-entry queue. The back end finds each channel's median by
// bit-serial rank selection, re-reading the (2r+1)^2 window from the single
// line-store read port once per bit. Input items are taken one per cycle
// while the queue has room and the row being written is not still needed
// by the oldest queued job; after the frame's last result is queued, input
// waits until it has been computed. The line store has no clearing pass.
module zero_padded_median_filter
    import zpmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);
    localparam int MAXR   = MAX_KERNEL / 2;
    localparam int ROWS   = 2 * MAXR + 2;
    localparam int RadCap = (MAXR > 3) ? 3 : MAXR;
    localparam int ColW   = $clog2(MAX_WIDTH);
    localparam int SlotW  = $clog2(ROWS);
    localparam int AW     = $clog2(ROWS * MAX_WIDTH);
    localparam int JW     = 1 + SlotW + ColW + 16;

    logic [10:0] r_width;
    logic [15:0] r_height;
    logic [2:0]  r_kernel;
    logic        r_three;

    logic [12:0]     w_eff;
    logic [ColW-1:0] wm1;
    t_geom           geom;

    logic            wr_en, rd_en, q_push, q_pop, q_empty, q_full;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [23:0]     wr_data, rd_data;
    logic [JW-1:0]   job, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 16'd1;
            r_kernel <= 3'd3;
            r_three  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[15:0];
                CFG_KERNEL_SIZE:   r_kernel <= i_cfg_data[2:0];
                CFG_THREE_CHANNEL: r_three  <= i_cfg_data[0];
                default:           r_three  <= r_three;
            endcase
        end
    end

    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = 13'd1;
        end else if ({2'b0, r_width} > 13'(MAX_WIDTH)) begin
            w_eff = 13'(MAX_WIDTH);
        end else begin
            w_eff = {2'b0, r_width};
        end
        wm1        = ColW'(w_eff - 13'd1);
        geom.hm1   = (r_height == 16'd0) ? 16'd0 : r_height - 16'd1;
        geom.rad   = (int'(r_kernel[2:1]) > RadCap) ? 2'(RadCap) : r_kernel[2:1];
        geom.three = r_three;
    end

    zpmf_ram #(.W(24), .DEPTH(ROWS * MAX_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    zpmf_front #(.MAX_WIDTH(MAX_WIDTH), .ROWS(ROWS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cfg_we),
        .i_wm1     (wm1),
        .i_geom    (geom),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_item),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_push    (q_push),
        .o_job     (job),
        .i_q_full  (q_full),
        .i_q_empty (q_empty),
        .i_head    (head),
        .i_pop     (q_pop)
    );

    zpmf_queue #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    zpmf_back #(.MAX_WIDTH(MAX_WIDTH), .ROWS(ROWS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wm1     (wm1),
        .i_geom    (geom),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (q_pop),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("job popped from empty queue");

    a_rd_with_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !q_empty) else $error("line read without a job");

    a_single_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_three) |-> (o_out_item.median1 == 8'd0
                                       && o_out_item.median2 == 8'd0))
        else $error("unused channel median not zero");

endmodule
`default_nettype wire
